// ===== src/lota_pkg.sv =====
// Package for the LoRa time-on-air core: field widths, configuration
// register indexes and pipeline stage layout. No dependencies.
package lota_pkg;

  localparam int LEN_W      = 8;
  localparam int SF_W       = 4;
  localparam int BW_W       = 19;
  localparam int CR_W       = 4;
  localparam int PRE_W      = 16;
  localparam int AIRTIME_W  = 26;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int SDIV_W      = 12;
  localparam int SDEN_W      = 6;
  localparam int DIVISOR_W   = BW_W + 2;
  localparam int QRT_W       = 19;
  localparam int PROD_W      = 29;
  localparam int NUMER_W     = 44;

  localparam int SDIV_LAST   = SDIV_W;
  localparam int STG_MULT    = SDIV_LAST + 1;
  localparam int STG_QRT     = SDIV_LAST + 2;
  localparam int STG_PROD    = SDIV_LAST + 3;
  localparam int STG_SHIFT   = SDIV_LAST + 4;
  localparam int BDIV_FIRST  = STG_SHIFT + 1;
  localparam int STG_LAST    = STG_SHIFT + AIRTIME_W;

  localparam logic [SF_W-1:0]    SF_RESET  = 4'd7;
  localparam logic [BW_W-1:0]    BW_RESET  = 19'd125000;
  localparam logic [CR_W-1:0]    CR_RESET  = 4'd5;
  localparam logic [PRE_W-1:0]   PRE_RESET = 16'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPREADING_FACTOR = 3'd0,
    CFG_BANDWIDTH_HZ     = 3'd1,
    CFG_CODING_RATE      = 3'd2,
    CFG_PREAMBLE_SYMBOLS = 3'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [SF_W-1:0]      sf;
    logic [CR_W-1:0]      cr;
    logic [PRE_W-1:0]     pre;
    logic                 low_sf;
    logic [DIVISOR_W-1:0] d;
    logic [SDIV_W-1:0]    sn;
    logic [SDEN_W-1:0]    sd;
    logic [SDEN_W-1:0]    sr;
    logic [SDIV_W-1:0]    sq;
    logic [15:0]          ext;
    logic [QRT_W-1:0]     qrt;
    logic [PROD_W-1:0]    prod;
    logic [NUMER_W-1:0]   bn;
    logic [DIVISOR_W-1:0] br;
    logic [AIRTIME_W-1:0] bq;
    logic                 sat;
  } stage_t;

endpackage

// ===== src/lora_time_on_air_core.sv =====
// An accepted word reaches the output through one register per stage.
// Throughput: one word per cycle; the whole pipeline holds while the output is stalled.
// Stages: front end, 12 steps of the payload-symbol divider, coding-rate multiply,
// quarter-symbol sum, scale by 1000, shift and overflow check, 26 divider steps.
// Reset (rst_ni low, asynchronous) clears all valid bits and loads the default
// configuration: SF 7, 125000 Hz, coding rate 5, preamble 8 symbols.
module lora_time_on_air_core
  import lota_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [LEN_W-1:0]      payload_length_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [AIRTIME_W-1:0]  airtime_millis_o
);

  logic [SF_W-1:0]  sf_q;
  logic [BW_W-1:0]  bw_q;
  logic [CR_W-1:0]  cr_q;
  logic [PRE_W-1:0] pre_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sf_q  <= SF_RESET;
      bw_q  <= BW_RESET;
      cr_q  <= CR_RESET;
      pre_q <= PRE_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SPREADING_FACTOR: sf_q  <= cfg_data_i[SF_W-1:0];
        CFG_BANDWIDTH_HZ:     bw_q  <= cfg_data_i[BW_W-1:0];
        CFG_CODING_RATE:      cr_q  <= cfg_data_i[CR_W-1:0];
        CFG_PREAMBLE_SYMBOLS: pre_q <= cfg_data_i[PRE_W-1:0];
        default: ;
      endcase
    end
  end

  stage_t stg_d [0:STG_LAST];
  stage_t stg_q [0:STG_LAST];
  logic   vld_q [0:STG_LAST];
  logic   advance;

  assign advance    = !vld_q[STG_LAST] || out_ready_i;
  assign in_ready_o = advance;

  logic [25:0]        ms1000;
  logic               de;
  logic               low_sf;
  logic signed [12:0] num;
  logic signed [7:0]  den;
  logic               epos;

  always_comb begin
    ms1000 = 26'd1000 << sf_q;
    de     = ms1000 >= {3'b0, bw_q, 4'b0};
    low_sf = (sf_q == 4'd5) || (sf_q == 4'd6);
    num    = $signed({2'b0, payload_length_i, 3'b0}) - $signed({7'b0, sf_q, 2'b0})
           + (low_sf ? 13'sd36 : 13'sd44);
    den    = $signed({2'b0, sf_q, 2'b0}) - (de ? 8'sd8 : 8'sd0);
    epos   = (num > 13'sd0) && (den > 8'sd0);
    stg_d[0]        = '0;
    stg_d[0].sf     = sf_q;
    stg_d[0].cr     = cr_q;
    stg_d[0].pre    = pre_q;
    stg_d[0].low_sf = low_sf;
    stg_d[0].d      = {bw_q, 2'b0};
    stg_d[0].sn     = epos ? SDIV_W'(num + 13'(den) - 13'sd1) : '0;
    stg_d[0].sd     = epos ? den[SDEN_W-1:0] : SDEN_W'(1);
  end

  for (genvar g = 1; g <= STG_LAST; g++) begin : g_stage
    if (g <= SDIV_LAST) begin : g_sdiv
      logic [SDEN_W:0] t;
      always_comb begin
        stg_d[g] = stg_q[g-1];
        t = {stg_q[g-1].sr, stg_q[g-1].sn[SDIV_W-g]};
        if (t >= {1'b0, stg_q[g-1].sd}) begin
          stg_d[g].sr = SDEN_W'(t - {1'b0, stg_q[g-1].sd});
          stg_d[g].sq[SDIV_W-g] = 1'b1;
        end else begin
          stg_d[g].sr = SDEN_W'(t);
        end
      end
    end else if (g == STG_MULT) begin : g_mult
      always_comb begin
        stg_d[g] = stg_q[g-1];
        stg_d[g].ext = {4'b0, stg_q[g-1].sq} * {12'b0, stg_q[g-1].cr};
      end
    end else if (g == STG_QRT) begin : g_qrt
      always_comb begin
        stg_d[g] = stg_q[g-1];
        stg_d[g].qrt = {1'b0, stg_q[g-1].pre, 2'b0}
                     + (stg_q[g-1].low_sf ? 19'd25 : 19'd17) + 19'd32
                     + QRT_W'({stg_q[g-1].ext, 2'b0});
      end
    end else if (g == STG_PROD) begin : g_prod
      always_comb begin
        stg_d[g] = stg_q[g-1];
        stg_d[g].prod = PROD_W'({10'b0, stg_q[g-1].qrt} * 29'd1000);
      end
    end else if (g == STG_SHIFT) begin : g_shift
      logic [NUMER_W-1:0] n;
      always_comb begin
        stg_d[g] = stg_q[g-1];
        n = NUMER_W'(stg_q[g-1].prod) << stg_q[g-1].sf;
        stg_d[g].bn  = n;
        stg_d[g].br  = DIVISOR_W'(n[NUMER_W-1:AIRTIME_W]);
        stg_d[g].bq  = '0;
        stg_d[g].sat = DIVISOR_W'(n[NUMER_W-1:AIRTIME_W]) >= stg_q[g-1].d;
      end
    end else begin : g_bdiv
      localparam int B = AIRTIME_W - 1 - (g - BDIV_FIRST);
      logic [DIVISOR_W:0] t;
      always_comb begin
        stg_d[g] = stg_q[g-1];
        t = {stg_q[g-1].br, stg_q[g-1].bn[B]};
        if (t >= {1'b0, stg_q[g-1].d}) begin
          stg_d[g].br = DIVISOR_W'(t - {1'b0, stg_q[g-1].d});
          stg_d[g].bq[B] = 1'b1;
        end else begin
          stg_d[g].br = DIVISOR_W'(t);
        end
      end
    end
  end

  for (genvar g = 0; g <= STG_LAST; g++) begin : g_reg
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (advance) begin
        vld_q[g] <= (g == 0) ? in_valid_i : vld_q[(g == 0) ? 0 : g-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (advance) begin
        stg_q[g] <= stg_d[g];
      end
    end
  end

  assign out_valid_o      = vld_q[STG_LAST];
  assign airtime_millis_o = stg_q[STG_LAST].sat ? '1 : stg_q[STG_LAST].bq;

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input accepted while the pipeline is stalled");

  a_word_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] && advance |=> vld_q[1])
    else $error("word lost between the first two stages");

  a_small_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[SDIV_LAST] |-> stg_q[SDIV_LAST].sr < stg_q[SDIV_LAST].sd)
    else $error("payload divider remainder out of range");

  a_big_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[STG_LAST] && !stg_q[STG_LAST].sat |-> stg_q[STG_LAST].br < stg_q[STG_LAST].d)
    else $error("airtime divider remainder out of range");

endmodule
